>>> sv/bhrs_pkg.sv
// ----------------------------------------------------------------------------
// bhrs_pkg
// Shared types, constants and codes for the B-tree hint range search block.
// ----------------------------------------------------------------------------
package bhrs_pkg;

	// table size and slot index width
	localparam int HINT_COUNT = 16;
	localparam int SLOT_BITS  = 12;

	// fixed widths of the item fields
	localparam int KEY_W   = 32;
	localparam int ENTRY_W = 4;
	localparam int MODE_W  = 2;

	// position within the table, wide enough to hold HINT_COUNT itself
	localparam int POS_W = $clog2(HINT_COUNT + 1);

	// slot spacing divisor and its reciprocal (exact for every SLOT_BITS-bit count)
	localparam int DIST_DIV    = HINT_COUNT + 1;
	localparam int DIV_LOG     = $clog2(DIST_DIV);
	localparam int RECIP_SHIFT = SLOT_BITS + DIV_LOG;
	localparam int RECIP_W     = SLOT_BITS + 1;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + DIST_DIV - 1) / DIST_DIV;
	localparam int PROD_W      = SLOT_BITS + RECIP_W;

	// largest node that does not use the hints
	localparam int SMALL_LIMIT = 2 * HINT_COUNT;

	typedef enum logic [0:0] {
		OP_QUERY = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF    = 2'd0,
		MODE_SCALAR = 2'd1,
		MODE_VECTOR = 2'd2
	} mode_t;

	// per-entry compare flags against the searched key
	typedef struct packed {
		logic [HINT_COUNT-1:0] ge;
		logic [HINT_COUNT-1:0] ne;
	} hint_cmp_t;

	// one result
	typedef struct packed {
		logic [SLOT_BITS-1:0] lower_bound;
		logic                 lower_valid;
		logic [SLOT_BITS-1:0] upper_bound;
		logic                 upper_valid;
	} bound_t;

endpackage

>>> sv/bhrs_hint_table.sv
// ----------------------------------------------------------------------------
// bhrs_hint_table
// Register table of sampled key heads with parallel compare against a key.
// ----------------------------------------------------------------------------
module bhrs_hint_table
	import bhrs_pkg::*;
(
	input  logic               clk,
	input  logic               write_en,
	input  logic [ENTRY_W-1:0] write_index,
	input  logic [KEY_W-1:0]   write_value,
	input  logic [KEY_W-1:0]   key,
	output hint_cmp_t          cmp
);

	logic [KEY_W-1:0] entry_q [HINT_COUNT];

	// entry write, indexes past the table are dropped
	always_ff @(posedge clk) begin
		for (int i = 0; i < HINT_COUNT; i++) begin
			if (write_en && (32'(write_index) == i)) begin
				entry_q[i] <= write_value;
			end
		end
	end

	// parallel compare of every entry
	always_comb begin
		for (int i = 0; i < HINT_COUNT; i++) begin
			cmp.ge[i] = (entry_q[i] >= key);
			cmp.ne[i] = (entry_q[i] != key);
		end
	end

endmodule

>>> sv/bhrs_range_calc.sv
// ----------------------------------------------------------------------------
// bhrs_range_calc
// Finds the first entry at or above the key and the first later differing
// entry, then scales both positions by the slot spacing.
// ----------------------------------------------------------------------------
module bhrs_range_calc
	import bhrs_pkg::*;
(
	input  hint_cmp_t            cmp,
	input  logic                 enable,
	input  mode_t                mode,
	input  logic [SLOT_BITS-1:0] spacing,
	output bound_t               result
);

	logic [POS_W-1:0]           pos;
	logic [POS_W-1:0]           pos2;
	logic [POS_W-1:0]           pos2_inc;
	logic                       pos_found;
	logic                       pos2_found;
	logic [HINT_COUNT-1:0]      at_or_after;
	logic [POS_W+SLOT_BITS-1:0] lo_prod;
	logic [POS_W+SLOT_BITS-1:0] hi_prod;
	logic                       search_on;
	logic                       produce;

	// first entry at or above the key
	always_comb begin
		pos       = POS_W'(HINT_COUNT);
		pos_found = 1'b0;
		for (int i = 0; i < HINT_COUNT; i++) begin
			if (cmp.ge[i] && !pos_found) begin
				pos       = POS_W'(i);
				pos_found = 1'b1;
			end
		end
	end

	// entries at or after pos, as a running or of the ge flags
	always_comb begin
		at_or_after[0] = cmp.ge[0];
		for (int i = 1; i < HINT_COUNT; i++) begin
			at_or_after[i] = at_or_after[i-1] | cmp.ge[i];
		end
	end

	// first entry at or after pos that differs from the key
	always_comb begin
		pos2       = POS_W'(HINT_COUNT);
		pos2_found = 1'b0;
		for (int i = 0; i < HINT_COUNT; i++) begin
			if (cmp.ne[i] && at_or_after[i] && !pos2_found) begin
				pos2       = POS_W'(i);
				pos2_found = 1'b1;
			end
		end
	end

	// scale positions by the spacing
	assign pos2_inc = pos2 + POS_W'(1);
	assign lo_prod  = (POS_W+SLOT_BITS)'(pos) * (POS_W+SLOT_BITS)'(spacing);
	assign hi_prod  = (POS_W+SLOT_BITS)'(pos2_inc) * (POS_W+SLOT_BITS)'(spacing);

	// vector mode gives nothing when no entry is at or above the key
	always_comb begin
		case (mode)
			MODE_SCALAR: search_on = 1'b1;
			MODE_VECTOR: search_on = pos_found;
			default:     search_on = 1'b0;
		endcase
	end

	assign produce = enable && search_on;

	always_comb begin
		result.lower_valid = produce;
		result.lower_bound = produce ? lo_prod[SLOT_BITS-1:0] : '0;
		result.upper_valid = produce && pos2_found;
		result.upper_bound = (produce && pos2_found) ? hi_prod[SLOT_BITS-1:0] : '0;
	end

endmodule

>>> sv/btree_hint_range_search.sv
// ----------------------------------------------------------------------------
// btree_hint_range_search
// Hint table for one B-tree node that narrows the binary-search range of a
// key lookup. Write transactions load table entries, query transactions
// return lower and upper slot bounds with valid flags.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   in      | in_valid/in_ready + item fields   | input
//   out     | out_valid/out_ready + bounds      | output
//   cfg     | cfg_write_en, cfg_write_data      | input
//
// One transaction per cycle sustained while out_ready stays high; each passes
// through the input register, then the result register.
// The slot spacing is computed into the input register; compares, position
// search and scaling run between the input and result registers.
// Reset clears the valid flags and sets search mode to scalar; table entries
// are undefined until written.
// A stalled result holds; one more transaction waits in the input register.
// ----------------------------------------------------------------------------
module btree_hint_range_search
	import bhrs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [MODE_W-1:0]    cfg_write_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [ENTRY_W-1:0]   entry_index,
	input  logic [KEY_W-1:0]     entry_value,
	input  logic [KEY_W-1:0]     search_key,
	input  logic [SLOT_BITS-1:0] slot_count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SLOT_BITS-1:0] lower_bound,
	output logic                 lower_valid,
	output logic [SLOT_BITS-1:0] upper_bound,
	output logic                 upper_valid
);

	mode_t                mode_q;
	logic                 valid_s1;
	op_t                  op_s1;
	logic [ENTRY_W-1:0]   index_s1;
	logic [KEY_W-1:0]     value_s1;
	logic [KEY_W-1:0]     key_s1;
	logic [SLOT_BITS-1:0] spacing_s1;
	logic                 big_s1;
	logic                 valid_s2;
	bound_t               result_s2;

	logic                 advance;
	logic                 accept;
	logic [PROD_W-1:0]    spacing_prod;
	hint_cmp_t            cmp;
	bound_t               result;

	// search mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SCALAR;
		end else if (cfg_write_en) begin
			mode_q <= mode_t'(cfg_write_data);
		end
	end

	// handshake
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// slot spacing by reciprocal multiply
	assign spacing_prod = PROD_W'(slot_count) * PROD_W'(RECIP);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_t'(operation);
			index_s1   <= entry_index;
			value_s1   <= entry_value;
			key_s1     <= search_key;
			spacing_s1 <= SLOT_BITS'(spacing_prod[PROD_W-1:RECIP_SHIFT]);
			big_s1     <= (32'(slot_count) > SMALL_LIMIT);
		end
	end

	// table, written as the write transaction leaves the input register
	bhrs_hint_table u_table (
		.clk         (clk),
		.write_en    (advance && (op_s1 == OP_WRITE)),
		.write_index (index_s1),
		.write_value (value_s1),
		.key         (key_s1),
		.cmp         (cmp)
	);

	bhrs_range_calc u_calc (
		.cmp     (cmp),
		.enable  ((op_s1 == OP_QUERY) && big_s1),
		.mode    (mode_q),
		.spacing (spacing_s1),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign lower_bound = result_s2.lower_bound;
	assign lower_valid = result_s2.lower_valid;
	assign upper_bound = result_s2.upper_bound;
	assign upper_valid = result_s2.upper_valid;

endmodule

>>> tb/btree_hint_range_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btree_hint_range_search_tb
// Self-checking bench for the hint range search block. Write transactions
// preload the hint table, then a short directed table covers the extremes,
// every search mode and each corner case. Random phases follow, each starting
// with a sorted table load with repeated heads. A local model of the table
// and the search mode predicts every result, and results are checked in order
// against the oldest prediction. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module btree_hint_range_search_tb;
	import bhrs_pkg::*;

	// search mode code with no meaning, acts as hints off
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 180;

	typedef struct {
		logic [MODE_W-1:0]    mode;
		op_t                  op;
		logic [ENTRY_W-1:0]   idx;
		logic [KEY_W-1:0]     val;
		logic [KEY_W-1:0]     key;
		logic [SLOT_BITS-1:0] slots;
		bit                   has_fixed;
		bound_t               fixed_res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write_en = 1'b0;
	logic [MODE_W-1:0]    cfg_write_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 operation = 1'b0;
	logic [ENTRY_W-1:0]   entry_index = '0;
	logic [KEY_W-1:0]     entry_value = '0;
	logic [KEY_W-1:0]     search_key = '0;
	logic [SLOT_BITS-1:0] slot_count = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [SLOT_BITS-1:0] lower_bound;
	logic                 lower_valid;
	logic [SLOT_BITS-1:0] upper_bound;
	logic                 upper_valid;

	// local copy of the block state
	logic [KEY_W-1:0]  hint_mem [HINT_COUNT];
	logic [MODE_W-1:0] mode_now = MODE_SCALAR;

	bound_t bounds_due [$];
	int     mismatch_count = 0;
	bit     send_steady = 1'b0;

	// directed rows, preload ladder is i<<28 with entries 4..6 equal
	dir_row_t dir_rows [0:18] = '{
		'{MODE_SCALAR, OP_QUERY, 4'd0, 32'h0, 32'h0000_0000, 12'd4095, 1'b1,
			'{12'd0, 1'b1, 12'd480, 1'b1}},
		'{MODE_SCALAR, OP_QUERY, 4'd0, 32'h0, 32'hFFFF_FFFF, 12'd4095, 1'b1,
			'{12'd3840, 1'b1, 12'd0, 1'b0}},
		'{MODE_SCALAR, OP_QUERY, 4'd0, 32'h0, 32'h4000_0000, 12'd4095, 1'b0, '0},
		'{MODE_SCALAR, OP_QUERY, 4'd0, 32'h0, 32'h3500_0000, 12'd33, 1'b0, '0},
		'{MODE_SCALAR, OP_QUERY, 4'd0, 32'h0, 32'h4000_0000, 12'd32, 1'b1, '0},
		'{MODE_SCALAR, OP_QUERY, 4'd0, 32'h0, 32'h1234_5678, 12'd0, 1'b1, '0},
		'{MODE_VECTOR, OP_QUERY, 4'd0, 32'h0, 32'hFFFF_FFFF, 12'd4095, 1'b1, '0},
		'{MODE_VECTOR, OP_QUERY, 4'd0, 32'h0, 32'h4000_0000, 12'd2000, 1'b0, '0},
		'{MODE_VECTOR, OP_QUERY, 4'd0, 32'h0, 32'h0000_0000, 12'd4095, 1'b1,
			'{12'd0, 1'b1, 12'd480, 1'b1}},
		'{MODE_OFF, OP_QUERY, 4'd0, 32'h0, 32'h4000_0000, 12'd4095, 1'b1, '0},
		'{MODE_UNUSED, OP_QUERY, 4'd0, 32'h0, 32'h4000_0000, 12'd4095, 1'b1, '0},
		'{MODE_SCALAR, OP_WRITE, 4'd15, 32'hFFFF_FFFF, 32'h0, 12'd0, 1'b1, '0},
		'{MODE_SCALAR, OP_QUERY, 4'd0, 32'h0, 32'hFFFF_FFFF, 12'd4095, 1'b0, '0},
		'{MODE_VECTOR, OP_QUERY, 4'd0, 32'h0, 32'hFFFF_FFFF, 12'd4095, 1'b0, '0},
		'{MODE_SCALAR, OP_WRITE, 4'd0, 32'h0, 32'hFFFF_FFFF, 12'd4095, 1'b1, '0},
		'{MODE_SCALAR, OP_QUERY, 4'd0, 32'h0, 32'h0000_0001, 12'd4095, 1'b0, '0},
		'{MODE_SCALAR, OP_WRITE, 4'd7, 32'h4000_0000, 32'h0, 12'd0, 1'b1, '0},
		'{MODE_SCALAR, OP_QUERY, 4'd0, 32'h0, 32'h4000_0000, 12'd4094, 1'b0, '0},
		'{MODE_SCALAR, OP_QUERY, 4'd0, 32'h0, 32'h3FFF_FFFF, 12'd34, 1'b0, '0}
	};

	btree_hint_range_search uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.entry_index    (entry_index),
		.entry_value    (entry_value),
		.search_key     (search_key),
		.slot_count     (slot_count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.lower_bound    (lower_bound),
		.lower_valid    (lower_valid),
		.upper_bound    (upper_bound),
		.upper_valid    (upper_valid)
	);

	// clock
	always #5 clk = ~clk;

	// table update and range search for one transaction
	function automatic bound_t predict_bounds(op_t op, logic [ENTRY_W-1:0] idx,
			logic [KEY_W-1:0] val, logic [KEY_W-1:0] key,
			logic [SLOT_BITS-1:0] slots);
		bound_t      b;
		int unsigned spacing;
		int unsigned first_ge;
		int unsigned first_ne;
		int unsigned scaled;
		b = '0;
		if (op == OP_WRITE) begin
			if (idx < HINT_COUNT)
				hint_mem[idx] = val;
		end else if (slots > SMALL_LIMIT &&
				(mode_now == MODE_SCALAR || mode_now == MODE_VECTOR)) begin
			spacing = slots / (HINT_COUNT + 1);
			first_ge = HINT_COUNT;
			for (int i = 0; i < HINT_COUNT; i++) begin
				if (hint_mem[i] >= key) begin
					first_ge = i;
					break;
				end
			end
			// vector path gives up when every entry is below the key
			if (!(mode_now == MODE_VECTOR && first_ge == HINT_COUNT)) begin
				first_ne = HINT_COUNT;
				for (int i = first_ge; i < HINT_COUNT; i++) begin
					if (hint_mem[i] != key) begin
						first_ne = i;
						break;
					end
				end
				scaled = first_ge * spacing;
				b.lower_bound = scaled[SLOT_BITS-1:0];
				b.lower_valid = 1'b1;
				if (first_ne < HINT_COUNT) begin
					scaled = (first_ne + 1) * spacing;
					b.upper_bound = scaled[SLOT_BITS-1:0];
					b.upper_valid = 1'b1;
				end
			end
		end
		return b;
	endfunction

	// offer one transaction and record its expected result once accepted
	task automatic offer_item(op_t op, logic [ENTRY_W-1:0] idx, logic [KEY_W-1:0] val,
			logic [KEY_W-1:0] key, logic [SLOT_BITS-1:0] slots, bit has_fixed,
			bound_t fixed_res);
		int     gap;
		bound_t pred;
		if ($urandom_range(0, 39) == 0)
			send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		entry_index <= idx;
		entry_value <= val;
		search_key  <= key;
		slot_count  <= slots;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = predict_bounds(op, idx, val, key, slots);
		bounds_due.push_back(has_fixed ? fixed_res : pred);
	endtask

	// drain all results, then write the search mode
	task automatic set_mode(logic [MODE_W-1:0] m);
		in_valid <= 1'b0;
		while (bounds_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= m;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		mode_now = m;
	endtask

	// sorted table load with runs of equal heads
	task automatic load_sorted_table();
		logic [KEY_W-1:0] v;
		v = $urandom_range(0, 32'h0FFF_FFFF);
		for (int i = 0; i < HINT_COUNT; i++) begin
			offer_item(OP_WRITE, i[ENTRY_W-1:0], v, $urandom,
				SLOT_BITS'($urandom_range(0, 4095)), 1'b0, '0);
			if ($urandom_range(0, 2) != 0)
				v += $urandom_range(1, 32'h0FFF_FFFF);
		end
	endtask

	// stimulus
	initial begin
		logic [MODE_W-1:0]    phase_modes [6];
		logic [KEY_W-1:0]     k;
		logic [KEY_W-1:0]     v;
		logic [SLOT_BITS-1:0] s;
		logic [ENTRY_W-1:0]   ix;
		phase_modes = '{MODE_SCALAR, MODE_VECTOR, MODE_OFF, MODE_UNUSED, MODE_VECTOR,
			MODE_SCALAR};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// preload ladder so that no query touches an unwritten entry
		for (int i = 0; i < HINT_COUNT; i++) begin
			v = (i == 5 || i == 6) ? 32'h4000_0000 : (i << 28);
			offer_item(OP_WRITE, i[ENTRY_W-1:0], v, ~v, i[SLOT_BITS-1:0], 1'b1, '0);
		end

		// directed table
		for (int r = 0; r < $size(dir_rows); r++) begin
			if (r == 0 || dir_rows[r].mode != mode_now)
				set_mode(dir_rows[r].mode);
			offer_item(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].val, dir_rows[r].key,
				dir_rows[r].slots, dir_rows[r].has_fixed, dir_rows[r].fixed_res);
		end

		// random phases, one search mode each
		for (int ph = 0; ph < 6; ph++) begin
			set_mode(phase_modes[ph]);
			load_sorted_table();
			for (int n = 0; n < PHASE_ITEMS - HINT_COUNT; n++) begin
				ix = ENTRY_W'($urandom_range(0, HINT_COUNT - 1));
				if ($urandom_range(0, 4) == 0) begin
					// table noise: copies make duplicates, random values unsort
					v = $urandom_range(0, 1) ? hint_mem[$urandom_range(0, HINT_COUNT - 1)]
						: $urandom;
					offer_item(OP_WRITE, ix, v, $urandom,
						SLOT_BITS'($urandom_range(0, 4095)), 1'b0, '0);
				end else begin
					k = hint_mem[ix];
					case ($urandom_range(0, 9))
						0, 1, 2, 3: k = hint_mem[ix];
						4: k = hint_mem[ix] + 1;
						5: k = hint_mem[ix] - 1;
						6: k = '0;
						7: k = '1;
						default: k = $urandom;
					endcase
					case ($urandom_range(0, 9))
						0: s = SLOT_BITS'($urandom_range(0, SMALL_LIMIT));
						1: s = SLOT_BITS'($urandom_range(SMALL_LIMIT, SMALL_LIMIT + 20));
						2: s = SLOT_BITS'($urandom_range(4080, 4095));
						default: s = SLOT_BITS'($urandom_range(0, 4095));
					endcase
					offer_item(OP_QUERY, ENTRY_W'($urandom), $urandom, k, s, 1'b0, '0);
				end
			end
		end

		// wind down
		in_valid <= 1'b0;
		while (bounds_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// result side: random stalls, two long hold-offs, in-order compare
	initial begin
		int     stall;
		int     results_seen;
		bit     take_steady;
		bound_t exp_res;
		results_seen = 0;
		take_steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				take_steady = !take_steady;
			stall = take_steady ? 0 : $urandom_range(0, 5);
			if (results_seen == 400 || results_seen == 850)
				stall = 60;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (bounds_due.size() == 0) begin
				$error("result transaction with no transaction pending");
				mismatch_count++;
			end else begin
				exp_res = bounds_due.pop_front();
				if (lower_bound !== exp_res.lower_bound) begin
					$error("lower_bound: expected %0d, got %0d", exp_res.lower_bound,
						lower_bound);
					mismatch_count++;
				end
				if (lower_valid !== exp_res.lower_valid) begin
					$error("lower_valid: expected %0d, got %0d", exp_res.lower_valid,
						lower_valid);
					mismatch_count++;
				end
				if (upper_bound !== exp_res.upper_bound) begin
					$error("upper_bound: expected %0d, got %0d", exp_res.upper_bound,
						upper_bound);
					mismatch_count++;
				end
				if (upper_valid !== exp_res.upper_valid) begin
					$error("upper_valid: expected %0d, got %0d", exp_res.upper_valid,
						upper_valid);
					mismatch_count++;
				end
			end
			results_seen++;
		end
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
